[hdl/nrrc_pkg.sv]
// ---------------------------------------------------------------------------
// nrrc_pkg
// Shared types and codes of the node run range compressor.
// ---------------------------------------------------------------------------
`default_nettype none

package nrrc_pkg;

    localparam int FIELD_BITS = 16;

    // request codes
    localparam logic [1:0] REQ_NODE  = 2'd0;
    localparam logic [1:0] REQ_EMPTY = 2'd1;
    localparam logic [1:0] REQ_END   = 2'd2;

    // token kinds
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_RANGE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_ZERO   = 2'd3;

    // run direction
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [FIELD_BITS-1:0] node_value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]            token_kind;
        logic [FIELD_BITS-1:0] first_node;
        logic [FIELD_BITS-1:0] final_node;
        logic                  last_of_item;
    } tok_item_t;

    // up to two tokens produced by one request
    typedef struct packed {
        tok_item_t  tok0;
        tok_item_t  tok1;
        logic [1:0] count;
    } tok_pair_t;

endpackage

`default_nettype wire

[hdl/node_run_range_compressor.sv]
// ---------------------------------------------------------------------------
// node_run_range_compressor
// Compresses a stream of node numbers into single-node and range tokens.
// ---------------------------------------------------------------------------
`default_nettype none

// Channel   Signals                        Direction  Content
// req       req_valid / req_stall / req    in         req_type, node_value
// tok       tok_valid / tok_stall / tok    out        kind, first, final, last flag
//
// One request is taken per cycle while req_stall is low. A request is held in
// the input register, where the run tracker decides its tokens; they are
// loaded into the token pair register when the request is processed. After a
// request that yields two tokens (flush plus gap), the next request that yields
// tokens waits in the input register until the last held token leaves, since
// the output drains one token per transfer. Reset closes the run and empties
// both registers. tok_stall backs up into req_stall the same cycle.

module node_run_range_compressor #(
    parameter int NODE_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire nrrc_pkg::req_item_t  req,
    output logic                     tok_valid,
    input  wire logic                tok_stall,
    output nrrc_pkg::tok_item_t       tok
);
    import nrrc_pkg::*;

    // node bits above the 16-bit field never carry data
    localparam int RUN_BITS = (NODE_BITS < FIELD_BITS) ? NODE_BITS : FIELD_BITS;

    logic      in_vld_reg, in_vld_next;
    req_item_t in_item_reg;
    tok_pair_t pair;
    logic      pair_free;
    logic      process;
    logic      accept;

    // a request that makes no token never waits on the output
    assign process   = in_vld_reg && (pair.count == 2'd0 || pair_free);
    assign req_stall = in_vld_reg && !process;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (process)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= req;
        end
    end

    nrrc_run_tracker #(
        .RUN_BITS (RUN_BITS)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (process),
        .item    (in_item_reg),
        .pair    (pair)
    );

    nrrc_token_pair u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (process),
        .pair      (pair),
        .free      (pair_free),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok)
    );

endmodule

`default_nettype wire

[hdl/nrrc_run_tracker.sv]
// ---------------------------------------------------------------------------
// nrrc_run_tracker
// Holds the open run and decides the tokens one request produces.
// ---------------------------------------------------------------------------
`default_nettype none

module nrrc_run_tracker #(
    parameter int RUN_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire nrrc_pkg::req_item_t item,
    output nrrc_pkg::tok_pair_t      pair
);
    import nrrc_pkg::*;

    logic                open_reg,  open_next;
    logic [RUN_BITS-1:0] start_reg, start_next;
    logic [RUN_BITS-1:0] last_reg,  last_next;
    logic [1:0]          dir_reg,   dir_next;

    logic [RUN_BITS-1:0] v;
    logic [RUN_BITS:0]   last_inc;
    logic                up;
    logic                down;
    logic                cont;
    tok_item_t           flush_tok;
    tok_item_t           gap_tok;
    tok_item_t           none_tok;

    assign v        = item.node_value[RUN_BITS-1:0];
    // one bit wider so the top value does not wrap
    assign last_inc = {1'b0, last_reg} + {{RUN_BITS{1'b0}}, 1'b1};
    assign up       = ({1'b0, v} == last_inc);
    assign down     = (last_reg != '0) && (v == last_reg - RUN_BITS'(1));
    assign cont     = (dir_reg == DIR_UP) ? up : down;

    always_comb
    begin
        none_tok              = '0;
        flush_tok.token_kind  = (start_reg == last_reg) ? KIND_SINGLE : KIND_RANGE;
        flush_tok.first_node  = FIELD_BITS'(start_reg);
        flush_tok.final_node  = FIELD_BITS'(last_reg);
        flush_tok.last_of_item = 1'b0;
        gap_tok.token_kind    = (item.req_type == REQ_EMPTY) ? KIND_EMPTY : KIND_ZERO;
        gap_tok.first_node    = '0;
        gap_tok.final_node    = '0;
        gap_tok.last_of_item  = 1'b1;
    end

    always_comb
    begin
        open_next  = open_reg;
        start_next = start_reg;
        last_next  = last_reg;
        dir_next   = dir_reg;
        pair.tok0  = none_tok;
        pair.tok1  = none_tok;
        pair.count = 2'd0;

        unique case (item.req_type)
            REQ_END:
            begin
                if (open_reg)
                begin
                    pair.tok0              = flush_tok;
                    pair.tok0.last_of_item = 1'b1;
                    pair.count             = 2'd1;
                end
                open_next  = 1'b0;
                start_next = '0;
                last_next  = '0;
                dir_next   = DIR_NONE;
            end
            REQ_NODE, REQ_EMPTY:
            begin
                if (item.req_type == REQ_EMPTY || v == '0)
                begin
                    // gap: flush any open run, then the gap token
                    if (open_reg)
                    begin
                        pair.tok0  = flush_tok;
                        pair.tok1  = gap_tok;
                        pair.count = 2'd2;
                    end
                    else
                    begin
                        pair.tok0  = gap_tok;
                        pair.count = 2'd1;
                    end
                    open_next  = 1'b0;
                    start_next = '0;
                    last_next  = '0;
                    dir_next   = DIR_NONE;
                end
                else if (!open_reg)
                begin
                    open_next  = 1'b1;
                    start_next = v;
                    last_next  = v;
                    dir_next   = DIR_NONE;
                end
                else
                begin
                    if (dir_reg == DIR_NONE)
                    begin
                        if (up)
                        begin
                            dir_next = DIR_UP;
                        end
                        else if (down)
                        begin
                            dir_next = DIR_DOWN;
                        end
                        else
                        begin
                            // start equals last here, so the flush is a single
                            pair.tok0              = flush_tok;
                            pair.tok0.last_of_item = 1'b1;
                            pair.count             = 2'd1;
                            start_next             = v;
                        end
                    end
                    else if (!cont)
                    begin
                        pair.tok0              = flush_tok;
                        pair.tok0.last_of_item = 1'b1;
                        pair.count             = 2'd1;
                        start_next             = v;
                        dir_next               = DIR_NONE;
                    end
                    last_next = v;
                end
            end
            default:
            begin
                // unused request code: no token, state unchanged
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            start_reg <= '0;
            last_reg  <= '0;
            dir_reg   <= DIR_NONE;
        end
        else if (advance)
        begin
            open_reg  <= open_next;
            start_reg <= start_next;
            last_reg  <= last_next;
            dir_reg   <= dir_next;
        end
    end

endmodule

`default_nettype wire

[hdl/nrrc_token_pair.sv]
// ---------------------------------------------------------------------------
// nrrc_token_pair
// Result register holding up to two tokens; drains one per transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module nrrc_token_pair (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire nrrc_pkg::tok_pair_t  pair,
    output logic                     free,
    output logic                     tok_valid,
    input  wire logic                tok_stall,
    output nrrc_pkg::tok_item_t       tok
);
    import nrrc_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    tok_item_t  tok0_reg, tok0_next;
    tok_item_t  tok1_reg, tok1_next;
    logic       pop;

    assign tok_valid = (cnt_reg != 2'd0);
    assign tok       = tok0_reg;
    assign pop       = tok_valid && !tok_stall;
    // room for a new pair once the last held token leaves
    assign free      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && !tok_stall);

    always_comb
    begin
        cnt_next  = cnt_reg;
        tok0_next = tok0_reg;
        tok1_next = tok1_reg;
        if (load && pair.count != 2'd0)
        begin
            cnt_next  = pair.count;
            tok0_next = pair.tok0;
            tok1_next = pair.tok1;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            tok0_next = tok1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok0_reg <= tok0_next;
        tok1_reg <= tok1_next;
    end

endmodule

`default_nettype wire
